/* rtl/qkbe_pkg.sv */
// Shared types and constants for the quadrature knob and button event core.
// Used by qkbe_front, qkbe_fifo, qkbe_back and the top level.
// No dependencies.
package qkbe_pkg;

   // Input kind codes
   localparam logic [2:0] KIND_KNOB_PHASE = 3'd0;
   localparam logic [2:0] KIND_KNOB_SW    = 3'd1;
   localparam logic [2:0] KIND_STOP       = 3'd2;
   localparam logic [2:0] KIND_LIFT       = 3'd3;
   localparam logic [2:0] KIND_DESCENT    = 3'd4;

   // Result event codes
   localparam logic [2:0] EV_RIGHT   = 3'd1;
   localparam logic [2:0] EV_LEFT    = 3'd2;
   // Button events are EV_BUTTON_BASE + button slot
   localparam logic [2:0] EV_BUTTON_BASE = 3'd3;

   // Configuration register indexes
   localparam logic CSR_DEBOUNCE_MS  = 1'b0;
   localparam logic CSR_DETENT_STEPS = 1'b1;

   // Configuration reset values
   localparam logic [15:0] DEBOUNCE_RESET = 16'd200;
   localparam logic [2:0]  DETENT_RESET   = 3'd4;

   // Quadrature step: row is previous phase, column is new phase (a*2+b)
   localparam logic signed [1:0] STEP_TABLE [4][4] = '{
      '{ 2'sd0, -2'sd1,  2'sd1,  2'sd0},
      '{ 2'sd1,  2'sd0,  2'sd0, -2'sd1},
      '{-2'sd1,  2'sd0,  2'sd0,  2'sd1},
      '{ 2'sd0,  2'sd1, -2'sd1,  2'sd0}
   };

   // Command class passed from front to back
   typedef enum logic {
      OP_KNOB,
      OP_BUTTON
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [1:0]  phase;
      logic [1:0]  slot;
      logic [31:0] now_ms;
   } cmd_type;

   typedef struct packed {
      logic [15:0] debounce_ms;
      logic [2:0]  detent_steps;
   } cfg_type;

endpackage

/* rtl/qkbe_front.sv */
// Front end: unpacks request beats and classifies them into commands.
// Depends on qkbe_pkg; feeds qkbe_fifo.
module qkbe_front
   import qkbe_pkg::*;
(
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,
   input  logic [2:0]  req_tuser,
   input  logic        q_ready,
   output logic        q_push,
   output cmd_type     q_cmd
);

   logic legal_kind;
   logic [2:0] slot_wide;

   assign slot_wide = req_tuser - KIND_KNOB_SW;

   // Unused kinds are swallowed here: accepted, no command queued
   always_comb begin
      legal_kind   = 1'b1;
      q_cmd.op     = OP_BUTTON;
      q_cmd.slot   = slot_wide[1:0];
      q_cmd.phase  = {req_tdata[0], req_tdata[1]};
      q_cmd.now_ms = req_tdata[33:2];
      unique case (req_tuser) inside
         KIND_KNOB_PHASE: q_cmd.op = OP_KNOB;
         KIND_KNOB_SW, KIND_STOP, KIND_LIFT, KIND_DESCENT: q_cmd.op = OP_BUTTON;
         default: legal_kind = 1'b0;
      endcase
   end

   assign req_tready = q_ready;
   assign q_push     = req_tvalid && q_ready && legal_kind;

endmodule

/* rtl/qkbe_fifo.sv */
// Short command queue between front and back end.
// Depends on qkbe_pkg for the command type.
module qkbe_fifo
   import qkbe_pkg::*;
#(
   parameter int DEPTH = 2
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    ready,
   input  logic    pop,
   output logic    valid,
   output cmd_type pop_cmd
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   cmd_type       mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign ready   = (count_ff != FULL_CNT);
   assign valid   = (count_ff != '0);
   assign do_push = push && ready;
   assign do_pop  = pop && valid;
   assign pop_cmd = mem_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_cmd;
   end

endmodule

/* rtl/qkbe_back.sv */
// Back end: knob accumulator, button debounce and the response register.
// Depends on qkbe_pkg; pops commands from qkbe_fifo.
module qkbe_back
   import qkbe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       q_valid,
   input  cmd_type    q_cmd,
   output logic       q_pop,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata
);

   logic [1:0]        last_phase_ff, last_phase_in;
   logic              primed_ff, primed_in;
   logic signed [3:0] step_sum_ff, step_sum_in;
   logic signed [1:0] last_step_ff, last_step_in;
   logic [31:0]       press_time_ff [4];
   logic              rsp_valid_ff, rsp_valid_in;
   logic [2:0]        rsp_event_ff, rsp_event_in;

   logic signed [1:0] step;
   logic              reverse;
   logic signed [4:0] sum_base, sum_new, limit;
   logic [31:0]       elapsed;
   logic              press_ok;
   logic              emit;
   logic [2:0]        emit_code;

   // Pop whenever the response register is free or draining
   assign q_pop = q_valid && (!rsp_valid_ff || rsp_tready);

   // Knob step and accumulation
   assign step     = STEP_TABLE[last_phase_ff][q_cmd.phase];
   assign reverse  = (last_step_ff > 0 && step < 0) || (last_step_ff < 0 && step > 0);
   assign sum_base = reverse ? 5'sd0 : {step_sum_ff[3], step_sum_ff};
   assign sum_new  = sum_base + {{3{step[1]}}, step};
   assign limit    = $signed({2'b00, cfg.detent_steps});

   // Button debounce, wrapping time difference
   assign elapsed  = q_cmd.now_ms - press_time_ff[q_cmd.slot];
   assign press_ok = elapsed > {16'd0, cfg.debounce_ms};

   always_comb begin
      last_phase_in = last_phase_ff;
      primed_in     = primed_ff;
      step_sum_in   = step_sum_ff;
      last_step_in  = last_step_ff;
      emit          = 1'b0;
      emit_code     = EV_RIGHT;
      if (q_pop && q_cmd.op == OP_KNOB) begin
         last_phase_in = q_cmd.phase;
         primed_in     = 1'b1;
         if (primed_ff && step != 2'sd0) begin
            last_step_in = step;
            step_sum_in  = sum_new[3:0];
            if (sum_new >= limit) begin
               step_sum_in = 4'sd0;
               emit        = 1'b1;
               emit_code   = EV_RIGHT;
            end else if (sum_new <= -limit) begin
               step_sum_in = 4'sd0;
               emit        = 1'b1;
               emit_code   = EV_LEFT;
            end
         end
      end else if (q_pop && q_cmd.op == OP_BUTTON && press_ok) begin
         emit      = 1'b1;
         emit_code = EV_BUTTON_BASE + {1'b0, q_cmd.slot};
      end
   end

   // Response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_event_in = rsp_event_ff;
      if (rsp_tready) rsp_valid_in = 1'b0;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_event_in = emit_code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_phase_ff <= '0;
         primed_ff     <= 1'b0;
         step_sum_ff   <= '0;
         last_step_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < 4; i++) press_time_ff[i] <= '0;
      end else begin
         last_phase_ff <= last_phase_in;
         primed_ff     <= primed_in;
         step_sum_ff   <= step_sum_in;
         last_step_ff  <= last_step_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (q_pop && q_cmd.op == OP_BUTTON && press_ok)
            press_time_ff[q_cmd.slot] <= q_cmd.now_ms;
      end
   end

   always_ff @(posedge clock) begin
      rsp_event_ff <= rsp_event_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_event_ff};

endmodule

/* rtl/quadrature_knob_and_button_events_core.sv */
// Top level of the quadrature knob and button event core.
// Depends on qkbe_pkg, qkbe_front, qkbe_fifo and qkbe_back.
//
// Turns knob phase changes and button presses into right, left and button
// events. A request beat is taken whenever the QUEUE_DEPTH-entry command
// queue has room. The back end retires one command per clock while the
// response register is empty or being drained, and loads any result at the
// same edge that pops its command. The sustained rate is one item per cycle
// while the response is not stalled; a stalled response holds the back end,
// and once the queue fills, req_tready drops until a slot frees. The first
// knob beat after reset only records the phase. Button presses no more than
// debounce_ms after the last accepted press of the same button are dropped.
// Unused kinds are accepted and discarded. Configuration is written through
// csr_we/csr_index/csr_wdata; the user must write it only while the core is
// idle, which the core itself does not enforce.
module quadrature_knob_and_button_events_core
   import qkbe_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
)
(
   input  logic        clock,
   input  logic        reset,
   // request: tdata = phase_a[0], phase_b[1], now_ms[33:2], zero pad
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,
   // request: tuser = kind[2:0]
   input  logic [2:0]  req_tuser,
   // response: tdata = event_res[2:0], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,
   // configuration write port
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   cfg_type cfg_ff;
   logic    q_push, q_ready, q_pop, q_valid;
   cmd_type push_cmd, pop_cmd;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms  <= DEBOUNCE_RESET;
         cfg_ff.detent_steps <= DETENT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DEBOUNCE_MS:  cfg_ff.debounce_ms  <= csr_wdata;
            CSR_DETENT_STEPS: cfg_ff.detent_steps <= csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   qkbe_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_ready    (q_ready),
      .q_push     (q_push),
      .q_cmd      (push_cmd)
   );

   qkbe_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .ready    (q_ready),
      .pop      (q_pop),
      .valid    (q_valid),
      .pop_cmd  (pop_cmd)
   );

   qkbe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (q_valid),
      .q_cmd      (pop_cmd),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

/* dv/quadrature_knob_and_button_events_core_test.sv */
// Self-checking testbench for quadrature_knob_and_button_events_core.
// Depends on qkbe_pkg and the core RTL; a scoreboard class predicts the
// right, left and button events from the accepted request beats.
`timescale 1ns / 100ps

module quadrature_knob_and_button_events_core_test
   import qkbe_pkg::*;
;

   localparam int SETTLE_CYCLES  = 8;
   localparam int TIMEOUT_CYCLES = 200000;
   localparam int PHASE_ITEMS    = 76;
   localparam int NUM_SETTINGS   = 5;

   // Predicts knob detents and debounced presses, holds the events owed
   class event_scoreboard;
      logic [15:0] debounce_ms;
      logic [2:0]  detent_steps;
      logic [1:0]  last_phase;
      bit          primed;
      int          step_sum;
      int          last_dir;
      logic [31:0] last_press[4];
      logic [2:0]  owed_events[$];
      int          errors;

      function new();
         debounce_ms  = DEBOUNCE_RESET;
         detent_steps = DETENT_RESET;
         last_phase   = '0;
         primed       = 1'b0;
         step_sum     = 0;
         last_dir     = 0;
         foreach (last_press[i]) last_press[i] = '0;
         errors       = 0;
      endfunction

      function void write_reg(logic idx, logic [15:0] value);
         if (idx == CSR_DEBOUNCE_MS)
            debounce_ms = value;
         else
            detent_steps = value[2:0];
      endfunction

      // +1 along 0-2-3-1-0, -1 the other way, 0 for no change or a skip
      function int quad_delta(logic [1:0] from_ph, logic [1:0] to_ph);
         case ({from_ph, to_ph})
            4'b0010, 4'b1011, 4'b1101, 4'b0100: return 1;
            4'b0001, 4'b0111, 4'b1110, 4'b1000: return -1;
            default: return 0;
         endcase
      endfunction

      function void note_pin_event(logic [2:0] kind, logic a, logic b, logic [31:0] now);
         logic [1:0]  phase;
         logic [1:0]  slot;
         logic [31:0] elapsed;
         int          delta;
         phase = {a, b};
         if (kind == KIND_KNOB_PHASE) begin
            // first knob beat only records where the knob sits
            if (!primed) begin
               primed     = 1'b1;
               last_phase = phase;
               return;
            end
            delta      = quad_delta(last_phase, phase);
            last_phase = phase;
            if (delta != 0) begin
               if (delta * last_dir < 0) step_sum = 0;
               step_sum += delta;
               last_dir  = delta;
               if (step_sum >= int'(detent_steps)) begin
                  step_sum = 0;
                  owed_events.push_back(EV_RIGHT);
               end else if (step_sum <= -int'(detent_steps)) begin
                  step_sum = 0;
                  owed_events.push_back(EV_LEFT);
               end
            end
         end else if (kind <= KIND_DESCENT) begin
            slot    = 2'(kind - KIND_KNOB_SW);
            elapsed = now - last_press[slot];
            if (elapsed > {16'd0, debounce_ms}) begin
               last_press[slot] = now;
               owed_events.push_back(3'(EV_BUTTON_BASE + slot));
            end
         end
      endfunction

      function void check_user_event(logic [2:0] actual);
         logic [2:0] want;
         if (owed_events.size() == 0) begin
            $error("event_res: expected none, actual %0d", actual);
            errors++;
            return;
         end
         want = owed_events.pop_front();
         if (actual !== want) begin
            $error("event_res mismatch: expected %0d, actual %0d", want, actual);
            errors++;
         end
      endfunction

      function int pending();
         return owed_events.size();
      endfunction

      function void final_check();
         if (owed_events.size() != 0) begin
            $error("event_res: %0d events never arrived, oldest expected %0d, actual none",
                   owed_events.size(), owed_events[0]);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // phase_a[0], phase_b[1], now_ms[33:2], zero pad
   logic [2:0]  req_tuser = '0;   // kind[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // event_res[2:0], zero pad
   logic        csr_we = 1'b0;
   logic        csr_index = 1'b0;
   logic [15:0] csr_wdata = '0;

   event_scoreboard sb;
   int          cycle_count = 0;
   int          stall_count = 0;
   int          stall_mode = 0;

   // sender-side knob position and button time base
   logic [1:0]  knob_pos = '0;
   bit          knob_cw = 1'b1;
   logic [31:0] btn_ms = '0;
   logic [1:0]  next_cw[4]  = '{2'd2, 2'd0, 2'd3, 2'd1};
   logic [1:0]  next_ccw[4] = '{2'd1, 2'd3, 2'd0, 2'd2};

   quadrature_knob_and_button_events_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // watchdog
   initial begin
      while (cycle_count < TIMEOUT_CYCLES) @(posedge clock);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // response stall pattern: free flow, coin toss, light, long stalls
   always @(posedge clock) begin
      if (stall_count % 97 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         2: rsp_tready <= ($urandom_range(0, 7) != 0);
         default: rsp_tready <= ((stall_count % 24) < 6);
      endcase
      stall_count++;
   end

   // beat monitor: results checked, accepted requests predicted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_user_event(rsp_tdata[2:0]);
         if (req_tvalid && req_tready)
            sb.note_pin_event(req_tuser, req_tdata[0], req_tdata[1], req_tdata[33:2]);
      end
   end

   // present one request beat and hold it until taken
   task automatic send_item(logic [2:0] kind, logic a, logic b, logic [31:0] now);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {6'd0, now, b, a};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic idle_gap(int n);
      req_tvalid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // stop sending until every owed event is out, then let the pipe empty
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(logic [15:0] deb, logic [2:0] det);
      csr_we    <= 1'b1;
      csr_index <= CSR_DEBOUNCE_MS;
      csr_wdata <= deb;
      @(posedge clock);
      sb.write_reg(CSR_DEBOUNCE_MS, deb);
      csr_index <= CSR_DETENT_STEPS;
      csr_wdata <= {13'd0, det};
      @(posedge clock);
      sb.write_reg(CSR_DETENT_STEPS, {13'd0, det});
      csr_we    <= 1'b0;
   endtask

   // mostly clean rotation runs and button presses around the debounce edge
   task automatic run_random(int count, logic [15:0] deb);
      int          sent;
      int          burst;
      int          r;
      logic [2:0]  kind;
      logic [1:0]  ph;
      logic [31:0] now;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 24);
         for (int j = 0; j < burst && sent < count; j++) begin
            r    = $urandom_range(0, 99);
            now  = $urandom;
            ph   = 2'($urandom_range(0, 3));
            kind = KIND_KNOB_PHASE;
            if (r < 55) begin
               if ($urandom_range(0, 15) == 0) knob_cw = !knob_cw;
               ph = knob_cw ? next_cw[knob_pos] : next_ccw[knob_pos];
            end else if (r < 62) begin
               // random phase: repeats and skipped states
            end else if (r < 92) begin
               kind = 3'($urandom_range(1, 4));
               if ($urandom_range(0, 9) == 0)
                  btn_ms = $urandom;
               else
                  btn_ms = btn_ms + $urandom_range(0, int'(deb) + int'(deb) / 2 + 2);
               now = btn_ms;
            end else begin
               kind = 3'($urandom_range(5, 7));
            end
            if (kind == KIND_KNOB_PHASE) knob_pos = ph;
            send_item(kind, ph[1], ph[0], now);
            sent++;
         end
         if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 8));
      end
   endtask

   initial begin
      logic [15:0] deb_list[NUM_SETTINGS];
      logic [2:0]  det_list[NUM_SETTINGS];
      sb = new();
      deb_list = '{16'd200, 16'd0, 16'hFFFF, 16'd0, 16'($urandom_range(1, 400))};
      det_list = '{3'd4, 3'd1, 3'd7, 3'd0, 3'($urandom_range(1, 7))};
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed part, reset settings: debounce 200, four steps per detent
      send_item(KIND_STOP, 1'b1, 1'b1, 32'd0);              // early press, dropped
      send_item(KIND_STOP, 1'b0, 1'b1, 32'd200);            // at the limit, dropped
      send_item(KIND_STOP, 1'b1, 1'b0, 32'd201);            // accepted
      send_item(KIND_KNOB_PHASE, 1'b1, 1'b1, 32'hFFFF_FFFF); // primes phase 3
      send_item(KIND_KNOB_PHASE, 1'b0, 1'b1, 32'd0);        // 3->1
      send_item(KIND_KNOB_PHASE, 1'b0, 1'b0, 32'd0);        // 1->0
      send_item(KIND_KNOB_PHASE, 1'b1, 1'b0, 32'd0);        // 0->2
      send_item(KIND_KNOB_PHASE, 1'b1, 1'b1, 32'd0);        // 2->3, right
      send_item(KIND_KNOB_PHASE, 1'b1, 1'b1, 32'd5);        // no change
      send_item(KIND_KNOB_PHASE, 1'b0, 1'b0, 32'd5);        // skipped state
      send_item(KIND_KNOB_PHASE, 1'b0, 1'b1, 32'd0);        // reverse, sum cleared
      send_item(KIND_KNOB_PHASE, 1'b1, 1'b1, 32'd0);
      send_item(KIND_KNOB_PHASE, 1'b1, 1'b0, 32'd0);
      send_item(KIND_KNOB_PHASE, 1'b0, 1'b0, 32'd0);        // left
      send_item(KIND_KNOB_PHASE, 1'b1, 1'b0, 32'd0);        // reverse again
      send_item(KIND_KNOB_SW, 1'b0, 1'b0, 32'hFFFF_FFFF);
      send_item(KIND_KNOB_SW, 1'b1, 1'b1, 32'h0000_0010);   // wrapped, too soon
      send_item(KIND_KNOB_SW, 1'b0, 1'b1, 32'd200);         // wrapped, 201 later
      send_item(KIND_LIFT, 1'b1, 1'b0, 32'hFFFF_FF00);
      send_item(KIND_DESCENT, 1'b1, 1'b1, 32'h8000_0000);
      send_item(3'd5, 1'b1, 1'b1, 32'hFFFF_FFFF);           // unused kinds
      send_item(3'd6, 1'b0, 1'b1, 32'h5555_5555);
      send_item(3'd7, 1'b1, 1'b0, 32'hAAAA_AAAA);
      knob_pos = 2'd2;
      btn_ms   = 32'h8000_0000;
      drain();

      // random part over several settings, extremes included
      for (int i = 0; i < NUM_SETTINGS; i++) begin
         set_config(deb_list[i], det_list[i]);
         run_random(PHASE_ITEMS, deb_list[i]);
         drain();
      end

      sb.final_check();
      if (sb.errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
